// ----- hdl/rfae_pkg.sv -----
// ----------------------------------------------------------------------------
// rfae_pkg: shared types and constants for the register file ALU executor.
// Holds opcodes, field widths and default sizes used by all modules.
// ----------------------------------------------------------------------------
package rfae_pkg;

    localparam int unsigned REG_COUNT_DEFAULT = 1024;
    localparam int unsigned DATA_W = 64;
    localparam int unsigned IDX_W = 10;
    localparam int unsigned OP_W = 5;

    typedef enum logic [OP_W-1:0] {
        OP_ADD  = 5'd0,  OP_SUB  = 5'd1,  OP_MUL  = 5'd2,  OP_DIV  = 5'd3,
        OP_REM  = 5'd4,  OP_SLT  = 5'd5,  OP_XOR  = 5'd6,  OP_AND  = 5'd7,
        OP_OR   = 5'd8,  OP_XORI = 5'd9,  OP_ANDI = 5'd10, OP_ORI  = 5'd11,
        OP_ADDI = 5'd12, OP_SLL  = 5'd13, OP_SRL  = 5'd14, OP_SLLI = 5'd15,
        OP_SRLI = 5'd16, OP_SLTI = 5'd17, OP_BLT  = 5'd18, OP_BGE  = 5'd19,
        OP_BEQ  = 5'd20, OP_BNE  = 5'd21, OP_JAL  = 5'd22, OP_JALR = 5'd23
    } op_t;

    typedef struct packed {
        logic        start;
        logic        is_rem;
        logic [63:0] dividend;
        logic [63:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } div_rsp_t;

endpackage

// ----- hdl/rfae_divider.sv -----
// ----------------------------------------------------------------------------
// rfae_divider: unsigned 64-bit radix-2 restoring divider.
// One quotient bit per cycle; divide by zero handled by the caller.
// ----------------------------------------------------------------------------
module rfae_divider (
    input  logic              aclk,
    input  logic              aresetn,
    input  rfae_pkg::div_req_t req,
    output rfae_pkg::div_rsp_t rsp
);

    logic        busy_reg;
    logic [6:0]  cnt_reg;
    logic [63:0] quo_reg;
    logic [63:0] rem_reg;
    logic [63:0] dvs_reg;
    logic        is_rem_reg;
    logic        done_reg;
    logic [64:0] trial;

    assign trial = {rem_reg, quo_reg[63]} - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg   <= 1'b1;
                cnt_reg    <= 7'd64;
                quo_reg    <= req.dividend;
                rem_reg    <= '0;
                dvs_reg    <= req.divisor;
                is_rem_reg <= req.is_rem;
            end else if (busy_reg) begin
                if (!trial[64]) begin
                    rem_reg <= trial[63:0];
                    quo_reg <= {quo_reg[62:0], 1'b1};
                end else begin
                    rem_reg <= {rem_reg[62:0], quo_reg[63]};
                    quo_reg <= {quo_reg[62:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = is_rem_reg ? rem_reg : quo_reg;

endmodule

// ----- hdl/register_file_alu_executor_core.sv -----
// ----------------------------------------------------------------------------
// register_file_alu_executor_core: executes one instruction per request
// against a 64-bit register file held in a synchronous memory.
// ----------------------------------------------------------------------------
// Channel  Dir  Ports            Contents
// s_axis   in   s_tvalid/tready  op, dest_reg, src_reg, third_operand, position
// m_axis   out  m_tvalid/tready  written_value .. error
//
// After reset a clearing pass zeroes the memory with s_tready low. From
// acceptance to the next acceptance each request passes through reads of the
// single read port (B, C, A), an execute step with write-back and a step that
// loads the output register. mul adds a multiply state on a 32-bit multiplier;
// div and rem wait in a divide state for the serial divider unless the divisor
// is zero. The result waits in an output register; a stall on m_tready holds
// it and blocks only the next request's completion.
module register_file_alu_executor_core #(
    parameter int unsigned REG_COUNT = rfae_pkg::REG_COUNT_DEFAULT
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    // op[4:0], dest_reg[14:5], src_reg[24:15], third_operand[88:25],
    // position[152:89], zero fill to 160
    input  logic [159:0]  s_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    // written_value[63:0], wrote[64], jump_taken[65], jump_target[129:66],
    // skip_set[130], skip_value[194:131], leave_compile_mode[195],
    // args_consumed[197:196], error[198], zero fill to 200
    output logic [199:0]  m_tdata
);

    localparam int unsigned AW = $clog2(REG_COUNT);

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_RD_B, ST_RD_C, ST_RD_A, ST_MUL, ST_EXEC, ST_DIV, ST_OUT
    } state_t;

    state_t       state_reg;
    logic [AW:0]  clr_reg;
    logic [63:0]  mem [REG_COUNT];
    logic [63:0]  rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic         wr_en;
    logic [AW-1:0] wr_addr;
    logic [63:0]  wr_data;

    logic [4:0]   op_reg;
    logic [9:0]   a_reg, b_reg;
    logic [63:0]  c_reg, pos_reg, x_reg, yr_reg, l_reg;
    logic [199:0] out_reg;
    logic         out_valid_reg;
    logic         load_out;

    logic [63:0]  mul_acc_reg;
    logic [1:0]   mul_step_reg;
    logic [31:0]  mul_a, mul_b;
    logic [63:0]  mul_p;

    rfae_pkg::div_req_t div_req;
    rfae_pkg::div_rsp_t div_rsp;

    rfae_divider u_div (.aclk(aclk), .aresetn(aresetn), .req(div_req), .rsp(div_rsp));

    logic c_is_reg, bad, is_imm, is_div;
    logic [63:0] y, wval, dres;

    always_comb begin
        c_is_reg = (op_reg <= rfae_pkg::OP_OR) ||
                   (op_reg inside {[rfae_pkg::OP_SLL:rfae_pkg::OP_SRL]}) ||
                   (op_reg inside {[rfae_pkg::OP_BLT:rfae_pkg::OP_BNE]});
        bad = (op_reg > rfae_pkg::OP_JALR) || ({22'd0, a_reg} >= 32'(REG_COUNT)) ||
              ({22'd0, b_reg} >= 32'(REG_COUNT)) ||
              (c_is_reg && (c_reg >= 64'(REG_COUNT)));
        is_imm = !c_is_reg;
        y = is_imm ? c_reg : yr_reg;
        is_div = (op_reg == rfae_pkg::OP_DIV) || (op_reg == rfae_pkg::OP_REM);
    end

    always_comb begin
        mul_a = (mul_step_reg == 2'd2) ? x_reg[63:32] : x_reg[31:0];
        mul_b = (mul_step_reg == 2'd1) ? y[63:32] : y[31:0];
        mul_p = mul_a * mul_b;
    end

    always_comb begin
        case (op_reg)
            rfae_pkg::OP_ADD, rfae_pkg::OP_ADDI: wval = x_reg + y;
            rfae_pkg::OP_SUB:  wval = x_reg - y;
            rfae_pkg::OP_MUL:  wval = mul_acc_reg;
            rfae_pkg::OP_SLT, rfae_pkg::OP_SLTI: wval = {63'd0, x_reg < y};
            rfae_pkg::OP_XOR, rfae_pkg::OP_XORI: wval = x_reg ^ y;
            rfae_pkg::OP_AND, rfae_pkg::OP_ANDI: wval = x_reg & y;
            rfae_pkg::OP_OR, rfae_pkg::OP_ORI:   wval = x_reg | y;
            rfae_pkg::OP_SLL, rfae_pkg::OP_SLLI: wval = x_reg << y[5:0];
            default: wval = x_reg >> y[5:0];
        endcase
    end

    always_comb begin
        if (op_reg == rfae_pkg::OP_DIV) begin
            dres = (y == 64'd0) ? '1 : div_rsp.result;
        end else begin
            dres = (y == 64'd0) ? x_reg : div_rsp.result;
        end
        div_req.start    = (state_reg == ST_EXEC) && !bad && y != 64'd0 && is_div;
        div_req.is_rem   = (op_reg == rfae_pkg::OP_REM);
        div_req.dividend = x_reg;
        div_req.divisor  = y;
    end

    always_comb begin
        rd_addr = AW'(b_reg);
        case (state_reg)
            ST_IDLE: rd_addr = AW'(s_tdata[24:15]);
            ST_RD_B: rd_addr = c_reg[AW-1:0];
            ST_RD_C: rd_addr = AW'(a_reg);
            default: rd_addr = AW'(b_reg);
        endcase
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = AW'(a_reg);
        wr_data = wval;
        if (state_reg == ST_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = clr_reg[AW-1:0];
            wr_data = '0;
        end else if (state_reg == ST_EXEC && !bad) begin
            if (is_div) begin
                if (y == 64'd0) begin
                    wr_en   = 1'b1;
                    wr_data = dres;
                end
            end else if (op_reg <= rfae_pkg::OP_SLTI) begin
                wr_en = 1'b1;
            end else if (op_reg == rfae_pkg::OP_JAL || op_reg == rfae_pkg::OP_JALR) begin
                wr_en = 1'b1;
                wr_data = pos_reg;
            end
        end else if (state_reg == ST_DIV && div_rsp.done) begin
            wr_en = 1'b1;
            wr_data = div_rsp.result;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    logic taken;
    logic [199:0] res;
    always_comb begin
        case (op_reg)
            rfae_pkg::OP_BLT: taken = l_reg < x_reg;
            rfae_pkg::OP_BGE: taken = l_reg >= x_reg;
            rfae_pkg::OP_BEQ: taken = l_reg == x_reg;
            default:          taken = l_reg != x_reg;
        endcase
        res = '0;
        if (bad) begin
            res[198] = 1'b1;
        end else if (op_reg <= rfae_pkg::OP_SLTI) begin
            res[63:0] = is_div ? dres : wval;
            res[64] = 1'b1;
        end else if (op_reg <= rfae_pkg::OP_BNE) begin
            res[197:196] = 2'd3;
            if (taken) begin
                if (yr_reg != 64'd0) begin
                    res[65] = 1'b1;
                    res[129:66] = yr_reg;
                end else begin
                    res[130] = 1'b1;
                    res[194:131] = c_reg;
                end
            end
        end else if (op_reg == rfae_pkg::OP_JAL) begin
            res[63:0] = pos_reg;
            res[64] = 1'b1;
            res[197:196] = 2'd2;
            if ((a_reg == b_reg ? pos_reg : x_reg) != 64'd0) begin
                res[65] = 1'b1;
                res[129:66] = (a_reg == b_reg) ? pos_reg : x_reg;
            end else begin
                res[130] = 1'b1;
                res[194:131] = {54'd0, b_reg};
            end
        end else begin
            res[63:0] = pos_reg;
            res[64] = 1'b1;
            res[65] = 1'b1;
            res[129:66] = ((a_reg == b_reg) ? pos_reg : x_reg) + c_reg;
            res[195] = 1'b1;
            res[197:196] = 2'd3;
        end
    end

    assign load_out = (state_reg == ST_OUT) && (!out_valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && m_tready && !load_out) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (AW+1)'(REG_COUNT - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_tvalid) begin
                        op_reg  <= s_tdata[4:0];
                        a_reg   <= s_tdata[14:5];
                        b_reg   <= s_tdata[24:15];
                        c_reg   <= s_tdata[88:25];
                        pos_reg <= s_tdata[152:89];
                        state_reg <= ST_RD_B;
                    end
                end
                ST_RD_B: begin
                    x_reg <= rd_data_reg;
                    state_reg <= ST_RD_C;
                end
                ST_RD_C: begin
                    yr_reg <= rd_data_reg;
                    state_reg <= ST_RD_A;
                end
                ST_RD_A: begin
                    l_reg <= rd_data_reg;
                    mul_step_reg <= 2'd0;
                    if (op_reg == rfae_pkg::OP_MUL) begin
                        state_reg <= ST_MUL;
                    end else begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_MUL: begin
                    mul_step_reg <= mul_step_reg + 2'd1;
                    if (mul_step_reg == 2'd0) begin
                        mul_acc_reg <= mul_p;
                    end else begin
                        mul_acc_reg <= mul_acc_reg + {mul_p[31:0], 32'd0};
                    end
                    if (mul_step_reg == 2'd2) begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (!bad && is_div && y != 64'd0) begin
                        state_reg <= ST_DIV;
                    end else begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_DIV: begin
                    if (div_rsp.done) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (load_out) begin
                        out_reg       <= res;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: register file ALU executor core
// Sends instruction requests and predicts each result from its own model of
// the register file. Each result is checked field by field, in order.
// Both the request side and the result side pause at random.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned NREG = 1024;
    localparam longint unsigned CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic        error;
        logic [1:0]  args_consumed;
        logic        leave_compile_mode;
        logic [63:0] skip_value;
        logic        skip_set;
        logic [63:0] jump_target;
        logic        jump_taken;
        logic        wrote;
        logic [63:0] written_value;
    } outcome_t;

    typedef struct packed {
        logic [63:0] position;
        logic [63:0] third_operand;
        logic [9:0]  src_reg;
        logic [9:0]  dest_reg;
        logic [4:0]  op;
    } instr_t;

    class exec_scoreboard;
        logic [63:0] regs [NREG];
        outcome_t pending [$];
        int errors;

        function new();
            foreach (regs[i]) regs[i] = '0;
            errors = 0;
        endfunction

        function void note_request(instr_t ins);
            outcome_t o;
            logic [63:0] x, y, wv;
            logic c_reg, taken;
            logic [63:0] c;
            c = ins.third_operand;
            o = '0;
            c_reg = (ins.op <= rfae_pkg::OP_OR) || ins.op == rfae_pkg::OP_SLL
                || ins.op == rfae_pkg::OP_SRL
                || (ins.op >= rfae_pkg::OP_BLT && ins.op <= rfae_pkg::OP_BNE);
            if (ins.op > rfae_pkg::OP_JALR || (c_reg && c >= NREG)) begin
                o.error = 1'b1;
            end else begin
                x = regs[ins.src_reg];
                y = c_reg ? regs[c[9:0]] : c;
                if (ins.op <= rfae_pkg::OP_SLTI) begin
                    case (rfae_pkg::op_t'(ins.op))
                        rfae_pkg::OP_ADD, rfae_pkg::OP_ADDI: wv = x + y;
                        rfae_pkg::OP_SUB: wv = x - y;
                        rfae_pkg::OP_MUL: wv = x * y;
                        rfae_pkg::OP_DIV: wv = (y == 0) ? '1 : x / y;
                        rfae_pkg::OP_REM: wv = (y == 0) ? x : x % y;
                        rfae_pkg::OP_SLT, rfae_pkg::OP_SLTI: wv = (x < y) ? 64'd1 : 64'd0;
                        rfae_pkg::OP_XOR, rfae_pkg::OP_XORI: wv = x ^ y;
                        rfae_pkg::OP_AND, rfae_pkg::OP_ANDI: wv = x & y;
                        rfae_pkg::OP_OR, rfae_pkg::OP_ORI: wv = x | y;
                        rfae_pkg::OP_SLL, rfae_pkg::OP_SLLI: wv = x << y[5:0];
                        default: wv = x >> y[5:0];
                    endcase
                    regs[ins.dest_reg] = wv;
                    o.written_value = wv;
                    o.wrote = 1'b1;
                end else if (ins.op <= rfae_pkg::OP_BNE) begin
                    case (rfae_pkg::op_t'(ins.op))
                        rfae_pkg::OP_BLT:
                            taken = regs[ins.dest_reg] < regs[ins.src_reg];
                        rfae_pkg::OP_BGE:
                            taken = regs[ins.dest_reg] >= regs[ins.src_reg];
                        rfae_pkg::OP_BEQ:
                            taken = regs[ins.dest_reg] == regs[ins.src_reg];
                        default:
                            taken = regs[ins.dest_reg] != regs[ins.src_reg];
                    endcase
                    o.args_consumed = 2'd3;
                    if (taken) begin
                        if (regs[c[9:0]] != 0) begin
                            o.jump_taken = 1'b1;
                            o.jump_target = regs[c[9:0]];
                        end else begin
                            o.skip_set = 1'b1;
                            o.skip_value = c;
                        end
                    end
                end else if (ins.op == rfae_pkg::OP_JAL) begin
                    regs[ins.dest_reg] = ins.position;
                    o.written_value = ins.position;
                    o.wrote = 1'b1;
                    o.args_consumed = 2'd2;
                    if (regs[ins.src_reg] != 0) begin
                        o.jump_taken = 1'b1;
                        o.jump_target = regs[ins.src_reg];
                    end else begin
                        o.skip_set = 1'b1;
                        o.skip_value = 64'(ins.src_reg);
                    end
                end else begin
                    regs[ins.dest_reg] = ins.position;
                    o.written_value = ins.position;
                    o.wrote = 1'b1;
                    o.args_consumed = 2'd3;
                    o.jump_taken = 1'b1;
                    o.jump_target = regs[ins.src_reg] + c;
                    o.leave_compile_mode = 1'b1;
                end
            end
            pending.push_back(o);
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("tb: mismatch on %s: got %h, expected %h", what, got, want);
            errors++;
        endtask

        task check_result(outcome_t got);
            outcome_t w;
            if (pending.size() == 0) begin
                report("unexpected result", got.written_value, 0);
                return;
            end
            w = pending.pop_front();
            if (got.written_value !== w.written_value)
                report("written_value", got.written_value, w.written_value);
            if (got.wrote !== w.wrote) report("wrote", got.wrote, w.wrote);
            if (got.jump_taken !== w.jump_taken)
                report("jump_taken", got.jump_taken, w.jump_taken);
            if (got.jump_target !== w.jump_target)
                report("jump_target", got.jump_target, w.jump_target);
            if (got.skip_set !== w.skip_set) report("skip_set", got.skip_set, w.skip_set);
            if (got.skip_value !== w.skip_value)
                report("skip_value", got.skip_value, w.skip_value);
            if (got.leave_compile_mode !== w.leave_compile_mode)
                report("leave_compile_mode", got.leave_compile_mode, w.leave_compile_mode);
            if (got.args_consumed !== w.args_consumed)
                report("args_consumed", got.args_consumed, w.args_consumed);
            if (got.error !== w.error) report("error", got.error, w.error);
        endtask
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [159:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [199:0] m_tdata;

    exec_scoreboard sb = new();
    longint unsigned cycles = 0;

    register_file_alu_executor_core #(.REG_COUNT(NREG)) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(outcome_t'(m_tdata[198:0]));
    end

    // Result side: stall in bursts, with calm stretches.
    initial begin
        int n;
        @(posedge aclk);
        forever begin
            n = ($urandom_range(0, 3) == 0) ? 0 : pause_len();
            m_tready <= (n == 0);
            repeat (n + 1) @(posedge aclk);
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    end

    task send_request(instr_t ins);
        int n;
        n = pause_len();
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
        s_tdata <= {7'b0, ins};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(ins);
    endtask

    function automatic logic [63:0] rand64();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return {1'b1, 63'b0};
            3: return 64'($urandom_range(0, 70));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic instr_t make_instr(logic [4:0] op, logic [9:0] a, logic [9:0] b,
                                          logic [63:0] c, logic [63:0] pos);
        instr_t i;
        i.op = op; i.dest_reg = a; i.src_reg = b; i.third_operand = c; i.position = pos;
        return i;
    endfunction

    // Mostly small register indexes so values chain through the file.
    function automatic logic [9:0] pick_reg();
        return ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, 15));
    endfunction

    function automatic instr_t random_instr();
        logic [4:0] op;
        logic c_reg;
        logic [63:0] c;
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) op = 5'($urandom_range(24, 31));
        else if (r < 10)
            op = ($urandom_range(0, 1) == 0) ? rfae_pkg::OP_DIV : rfae_pkg::OP_REM;
        else op = 5'($urandom_range(0, 23));
        c_reg = (op <= rfae_pkg::OP_OR) || op == rfae_pkg::OP_SLL || op == rfae_pkg::OP_SRL
            || (op >= rfae_pkg::OP_BLT && op <= rfae_pkg::OP_BNE);
        if (c_reg)
            c = ($urandom_range(0, 19) == 0) ? rand64() : 64'(pick_reg());
        else
            c = rand64();
        return make_instr(op, pick_reg(), pick_reg(), c, rand64());
    endfunction

    initial begin
        instr_t ins;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_request(make_instr(rfae_pkg::OP_ADDI, 10'd1, 10'd0, '1, 64'd0));
        send_request(make_instr(rfae_pkg::OP_ADDI, 10'd2, 10'd0, 64'd5, 64'd0));
        send_request(make_instr(rfae_pkg::OP_ADDI, 10'd1023, 10'd0, {1'b1, 63'b0}, 64'd0));
        send_request(make_instr(rfae_pkg::OP_DIV, 10'd3, 10'd1, 64'd0, 64'd0));
        send_request(make_instr(rfae_pkg::OP_REM, 10'd4, 10'd1, 64'd0, 64'd0));
        send_request(make_instr(rfae_pkg::OP_DIV, 10'd5, 10'd1, 64'd2, 64'd0));
        send_request(make_instr(rfae_pkg::OP_REM, 10'd6, 10'd1023, 64'd2, 64'd0));
        send_request(make_instr(rfae_pkg::OP_MUL, 10'd7, 10'd1, 64'd1, 64'd0));
        send_request(make_instr(rfae_pkg::OP_SUB, 10'd8, 10'd0, 64'd2, 64'd0));
        send_request(make_instr(rfae_pkg::OP_SLT, 10'd9, 10'd2, 64'd1, 64'd0));
        send_request(make_instr(rfae_pkg::OP_XOR, 10'd10, 10'd1, 64'd1023, 64'd0));
        send_request(make_instr(rfae_pkg::OP_AND, 10'd11, 10'd1, 64'd2, 64'd0));
        send_request(make_instr(rfae_pkg::OP_OR, 10'd12, 10'd2, 64'd1023, 64'd0));
        send_request(make_instr(rfae_pkg::OP_SLLI, 10'd13, 10'd1,
                                64'hffff_ffff_ffff_ff7f, 64'd0));
        send_request(make_instr(rfae_pkg::OP_SRLI, 10'd14, 10'd1, 64'd63, 64'd0));
        send_request(make_instr(rfae_pkg::OP_SLL, 10'd15, 10'd2, 64'd2, 64'd0));
        send_request(make_instr(rfae_pkg::OP_SRL, 10'd15, 10'd1, 64'd2, 64'd0));
        send_request(make_instr(rfae_pkg::OP_XORI, 10'd16, 10'd0, '1, 64'd0));
        send_request(make_instr(rfae_pkg::OP_ANDI, 10'd16, 10'd1, 64'h0f0f, 64'd0));
        send_request(make_instr(rfae_pkg::OP_ORI, 10'd16, 10'd0, 64'h1, 64'd0));
        send_request(make_instr(rfae_pkg::OP_SLTI, 10'd17, 10'd2, 64'd6, 64'd0));
        send_request(make_instr(rfae_pkg::OP_BLT, 10'd2, 10'd1, 64'd1023, 64'd0));
        send_request(make_instr(rfae_pkg::OP_BNE, 10'd2, 10'd1, 64'd500, 64'd0));
        send_request(make_instr(rfae_pkg::OP_BEQ, 10'd2, 10'd1, 64'd2, 64'd0));
        send_request(make_instr(rfae_pkg::OP_BGE, 10'd1, 10'd2, 64'd1024, 64'd0));
        send_request(make_instr(rfae_pkg::OP_JAL, 10'd20, 10'd20, 64'd0, '1));
        send_request(make_instr(rfae_pkg::OP_JAL, 10'd21, 10'd600, 64'd0, 64'd7));
        send_request(make_instr(rfae_pkg::OP_JALR, 10'd22, 10'd22, '1, 64'd9));
        send_request(make_instr(5'd31, 10'd0, 10'd0, 64'd0, 64'd0));
        repeat (1150) begin
            ins = random_instr();
            send_request(ins);
        end
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
